/* rtl/sorted_key_table_unit_defines.svh */
// Assertion helpers for the engine of the sorted key table.
`ifndef SORTED_KEY_TABLE_UNIT_DEFINES_SVH
`define SORTED_KEY_TABLE_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SKT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SKT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/skt_pkg.sv */
package skt_pkg;

   localparam int KIND_W   = 2;
   localparam int KEY_W    = 15;
   localparam int SLOT_W   = 6;
   localparam int STATUS_W = 3;

   localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd0;
   localparam logic [KIND_W-1:0] KIND_INSERT = 2'd1;
   localparam logic [KIND_W-1:0] KIND_DELETE = 2'd2;

   localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd0;
   localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd1;
   localparam logic [STATUS_W-1:0] ST_DELETED  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_MISSING  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [KEY_W-1:0]  key;
   } req_type;

   typedef struct packed {
      logic [SLOT_W-1:0]   slot;
      logic [STATUS_W-1:0] status;
   } rsp_type;

   typedef struct packed {
      logic    done;
      rsp_type rsp;
   } eng_out_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SRCH,
      S_SCMP,
      S_CHECK,
      S_SHRD,
      S_SHWR,
      S_INRD,
      S_INWR
   } state_type;

endpackage

/* rtl/skt_ram.sv */
module skt_ram #(
   parameter int WIDTH = 15,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/skt_engine.sv */
`include "sorted_key_table_unit_defines.svh"

module skt_engine
   import skt_pkg::*;
#(
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  req_type                  req_data,
   output logic                     req_stall,
   input  logic                     take,
   output eng_out_type              eng_out,
   output logic                     ram_we,
   output logic [$clog2(DEPTH)-1:0] ram_waddr,
   output logic [KEY_W-1:0]         ram_wdata,
   output logic [$clog2(DEPTH)-1:0] ram_raddr,
   input  logic [KEY_W-1:0]         ram_rdata
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);
   localparam logic [CW-1:0] ONE = CW'(1);

   state_type state_ff, state_in;
   logic [KIND_W-1:0]   kind_ff, kind_in;
   logic [KEY_W-1:0]    key_ff, key_in;
   logic [CW-1:0]       lo_ff, lo_in;
   logic [CW-1:0]       hi_ff, hi_in;
   logic [CW-1:0]       idx_ff, idx_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [SLOT_W-1:0]   slot_ff, slot_in;
   logic [STATUS_W-1:0] status_ff, status_in;

   logic [CW-1:0] mid;
   logic [CW-1:0] idx_up;
   logic [CW-1:0] idx_dn;
   logic          hit;

   // A finished transaction waits in done_ff until the output register is free.
   logic done_ff, done_in;
   logic finish;

   assign mid    = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign idx_up = idx_ff + ONE;
   assign idx_dn = idx_ff - ONE;
   assign hit    = (lo_ff < count_ff) && (ram_rdata == key_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      kind_ff   <= kind_in;
      key_ff    <= key_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      idx_ff    <= idx_in;
      slot_ff   <= slot_in;
      status_ff <= status_in;
   end

   always_comb begin
      state_in  = state_ff;
      kind_in   = kind_ff;
      key_in    = key_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      idx_in    = idx_ff;
      count_in  = count_ff;
      slot_in   = slot_ff;
      status_in = status_ff;
      ram_we    = 1'b0;
      ram_waddr = idx_ff[AW-1:0];
      ram_wdata = ram_rdata;
      ram_raddr = lo_ff[AW-1:0];
      case (state_ff)
         S_IDLE: begin
            if (req_valid && !done_ff) begin
               kind_in  = req_data.kind;
               key_in   = req_data.key;
               lo_in    = '0;
               hi_in    = count_ff;
               state_in = S_SRCH;
            end
         end
         S_SRCH: begin
            if (lo_ff < hi_ff) begin
               ram_raddr = mid[AW-1:0];
               idx_in    = mid;
               state_in  = S_SCMP;
            end else begin
               ram_raddr = lo_ff[AW-1:0];
               state_in  = S_CHECK;
            end
         end
         S_SCMP: begin
            if (ram_rdata < key_ff) begin
               lo_in = idx_ff + ONE;
            end else begin
               hi_in = idx_ff;
            end
            state_in = S_SRCH;
         end
         S_CHECK: begin
            slot_in  = '0;
            state_in = S_IDLE;
            case (kind_ff)
               KIND_DELETE: begin
                  if (hit) begin
                     slot_in   = SLOT_W'(lo_ff);
                     status_in = ST_DELETED;
                     idx_in    = lo_ff;
                     state_in  = S_SHRD;
                  end else begin
                     status_in = ST_MISSING;
                  end
               end
               KIND_INSERT: begin
                  if (hit) begin
                     slot_in   = SLOT_W'(lo_ff);
                     status_in = ST_FOUND;
                  end else if (count_ff == FULL_COUNT) begin
                     status_in = ST_FULL;
                  end else begin
                     slot_in   = SLOT_W'(lo_ff);
                     status_in = ST_INSERTED;
                     idx_in    = count_ff;
                     state_in  = S_INRD;
                  end
               end
               default: begin
                  if (hit) begin
                     slot_in   = SLOT_W'(lo_ff);
                     status_in = ST_FOUND;
                  end else begin
                     status_in = ST_MISSING;
                  end
               end
            endcase
         end
         S_SHRD: begin
            if (idx_up < count_ff) begin
               ram_raddr = idx_up[AW-1:0];
               state_in  = S_SHWR;
            end else begin
               count_in = count_ff - ONE;
               state_in = S_IDLE;
            end
         end
         S_SHWR: begin
            ram_we    = 1'b1;
            ram_waddr = idx_ff[AW-1:0];
            ram_wdata = ram_rdata;
            idx_in    = idx_up;
            state_in  = S_SHRD;
         end
         S_INRD: begin
            if (idx_ff > lo_ff) begin
               ram_raddr = idx_dn[AW-1:0];
               state_in  = S_INWR;
            end else begin
               ram_we    = 1'b1;
               ram_waddr = lo_ff[AW-1:0];
               ram_wdata = key_ff;
               count_in  = count_ff + ONE;
               state_in  = S_IDLE;
            end
         end
         S_INWR: begin
            ram_we    = 1'b1;
            ram_waddr = idx_ff[AW-1:0];
            ram_wdata = ram_rdata;
            idx_in    = idx_dn;
            state_in  = S_INRD;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign finish = (state_ff != S_IDLE) && (state_in == S_IDLE);

   always_comb begin
      done_in = done_ff;
      if (done_ff && take) begin
         done_in = 1'b0;
      end
      if (finish) begin
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= done_in;
      end
   end

   assign req_stall          = (state_ff != S_IDLE) || done_ff;
   assign eng_out.done       = done_ff;
   assign eng_out.rsp.slot   = slot_ff;
   assign eng_out.rsp.status = status_ff;

   `SKT_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= FULL_COUNT,
      "fill count above depth")
   `SKT_ASSERT_NOW(a_search_order, clock, reset, state_ff == S_SRCH, lo_ff <= hi_ff,
      "search bounds crossed")
   `SKT_ASSERT_NOW(a_write_phase, clock, reset, ram_we,
      state_ff == S_SHWR || state_ff == S_INWR || state_ff == S_INRD,
      "table written outside a shift")
   `SKT_ASSERT_NEXT(a_count_steady, clock, reset,
      state_ff == S_IDLE || state_ff == S_SRCH || state_ff == S_SCMP,
      count_ff == $past(count_ff), "fill count moved during search")

endmodule

/* rtl/sorted_key_table_unit.sv */
// Channel   Direction  Payload                  Handshake
// req       in         req_type {kind, key}     req_valid / req_stall
// rsp       out        rsp_type {slot, status}  rsp_valid / rsp_stall
//
// A transaction runs a binary search, each probe a key read (S_SRCH) and a compare
// (S_SCMP), then a last key read and check (S_CHECK), and hands off the result.
// A delete that hits, or an insert of a new key, then shifts the later keys, one read and one write per moved key.
// Reset clears the fill count and the control state; the key RAM is not cleared.
// The result waits in an output register, so a stalled response holds the engine
// only once its next result is ready.
module sorted_key_table_unit
   import skt_pkg::*;
#(
   parameter int DEPTH = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int AW = $clog2(DEPTH);

   eng_out_type      eng_out;
   logic             take;
   logic             ram_we;
   logic [AW-1:0]    ram_waddr;
   logic [KEY_W-1:0] ram_wdata;
   logic [AW-1:0]    ram_raddr;
   logic [KEY_W-1:0] ram_rdata;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   skt_ram #(
      .WIDTH(KEY_W),
      .DEPTH(DEPTH)
   ) u_ram (
      .clock(clock),
      .we   (ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   skt_engine #(
      .DEPTH(DEPTH)
   ) u_engine (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_data (req_data),
      .req_stall(req_stall),
      .take     (take),
      .eng_out  (eng_out),
      .ram_we   (ram_we),
      .ram_waddr(ram_waddr),
      .ram_wdata(ram_wdata),
      .ram_raddr(ram_raddr),
      .ram_rdata(ram_rdata)
   );

   assign take = eng_out.done && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = eng_out.rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
